// ----- rtl/mats_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC address text splitter package
// Shared types, character codes and helper functions.
// ----------------------------------------------------------------------------
package mats_pkg;

  localparam int MATS_QUEUE_DEPTH = 2;
  localparam int MATS_BYTES_W     = 48;
  localparam int MATS_NIBBLES     = MATS_BYTES_W / 4;

  localparam logic [4:0] MATS_COLON_LEN = 5'd17;
  localparam logic [4:0] MATS_DOT_LEN   = 5'd14;
  localparam logic [4:0] MATS_COUNT_MAX = 5'd31;
  localparam logic [3:0] MATS_LAST_IDX  = 4'd15;

  localparam logic [15:0] MATS_U_COLON = 16'h003A;
  localparam logic [15:0] MATS_U_DASH  = 16'h002D;
  localparam logic [15:0] MATS_U_DOT   = 16'h002E;
  localparam logic [6:0]  MATS_A_COLON = 7'h3A;
  localparam logic [6:0]  MATS_A_ZERO  = 7'h30;
  localparam logic [6:0]  MATS_A_LOW_A = 7'h61;
  localparam logic [6:0]  MATS_A_UP_A  = 7'h41;

  typedef struct packed {
    logic                    ok;
    logic [MATS_BYTES_W-1:0] bytes;
  } mats_rec_t;

  // {is_hex, nibble}
  function automatic logic [4:0] mats_hex_decode(input logic [15:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      r = {1'b1, 4'(c - 16'h0030)};
    end else if (c >= 16'h0061 && c <= 16'h0066) begin
      r = {1'b1, 4'(c - 16'h0057)};
    end else if (c >= 16'h0041 && c <= 16'h0046) begin
      r = {1'b1, 4'(c - 16'h0037)};
    end
    return r;
  endfunction

  // nibble number (0 = most significant) printed at output slot idx
  function automatic logic [3:0] mats_nib_index(input logic [3:0] idx);
    logic [3:0] n;
    case (idx[2:0])
      3'd0: n = 4'd0;
      3'd1: n = 4'd1;
      3'd3: n = 4'd2;
      3'd4: n = 4'd3;
      3'd6: n = 4'd4;
      3'd7: n = 4'd5;
      default: n = 4'd0;
    endcase
    return idx[3] ? n + 4'd6 : n;
  endfunction

  function automatic logic [6:0] mats_hex_char(input logic [3:0] nib, input logic upper);
    logic [6:0] r;
    if (nib < 4'd10) begin
      r = MATS_A_ZERO + 7'(nib);
    end else begin
      r = (upper ? MATS_A_UP_A : MATS_A_LOW_A) + 7'(nib - 4'd10);
    end
    return r;
  endfunction

endpackage

// ----- rtl/mats_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC address text splitter front end
// Checks each code unit against both address forms, gathers nibbles, and
// pushes one record per address into the queue.
// ----------------------------------------------------------------------------
module mats_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         code_unit,
  input  logic                last,
  input  logic                q_full,
  output logic                q_push,
  output mats_pkg::mats_rec_t q_rec
);
  import mats_pkg::*;

  logic [4:0]  unit_count, unit_count_next;
  logic [15:0] first_separator, first_separator_next;
  logic        colon_form_ok, colon_form_ok_next;
  logic        dot_form_ok, dot_form_ok_next;
  logic [MATS_BYTES_W-1:0] colon_form_bytes, colon_form_bytes_next;
  logic [MATS_BYTES_W-1:0] dot_form_bytes, dot_form_bytes_next;
  logic [4:0]  hex;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hex      = mats_hex_decode(code_unit);

  always_comb begin
    first_separator_next  = first_separator;
    colon_form_ok_next    = colon_form_ok;
    dot_form_ok_next      = dot_form_ok;
    colon_form_bytes_next = colon_form_bytes;
    dot_form_bytes_next   = dot_form_bytes;

    if (unit_count < MATS_COLON_LEN) begin
      if (unit_count inside {5'd2, 5'd5, 5'd8, 5'd11, 5'd14}) begin
        if (unit_count == 5'd2) begin
          first_separator_next = code_unit;
          if (code_unit != MATS_U_COLON && code_unit != MATS_U_DASH) begin
            colon_form_ok_next = 1'b0;
          end
        end else if (code_unit != first_separator) begin
          colon_form_ok_next = 1'b0;
        end
      end else if (!hex[4]) begin
        colon_form_ok_next = 1'b0;
      end else begin
        colon_form_bytes_next = {colon_form_bytes[MATS_BYTES_W-5:0], hex[3:0]};
      end
    end

    if (unit_count < MATS_DOT_LEN) begin
      if (unit_count inside {5'd4, 5'd9}) begin
        if (code_unit != MATS_U_DOT) dot_form_ok_next = 1'b0;
      end else if (!hex[4]) begin
        dot_form_ok_next = 1'b0;
      end else begin
        dot_form_bytes_next = {dot_form_bytes[MATS_BYTES_W-5:0], hex[3:0]};
      end
    end

    unit_count_next = (unit_count == MATS_COUNT_MAX) ? unit_count : unit_count + 5'd1;

    q_rec.ok    = 1'b0;
    q_rec.bytes = '0;
    if (unit_count_next == MATS_COLON_LEN) begin
      q_rec.ok    = colon_form_ok_next;
      q_rec.bytes = colon_form_bytes_next;
    end else if (unit_count_next == MATS_DOT_LEN) begin
      q_rec.ok    = dot_form_ok_next;
      q_rec.bytes = dot_form_bytes_next;
    end
  end

  assign q_push = accept && last;

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      unit_count       <= '0;
      first_separator  <= '0;
      colon_form_ok    <= 1'b1;
      dot_form_ok      <= 1'b1;
      colon_form_bytes <= '0;
      dot_form_bytes   <= '0;
    end else if (accept) begin
      unit_count       <= unit_count_next;
      first_separator  <= first_separator_next;
      colon_form_ok    <= colon_form_ok_next;
      dot_form_ok      <= dot_form_ok_next;
      colon_form_bytes <= colon_form_bytes_next;
      dot_form_bytes   <= dot_form_bytes_next;
    end
  end

endmodule

// ----- rtl/mats_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC address text splitter record queue
// Small register FIFO between the front end and the emitter.
// ----------------------------------------------------------------------------
module mats_queue #(
  parameter int DEPTH = mats_pkg::MATS_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mats_pkg::mats_rec_t push_rec,
  input  logic                pop,
  output mats_pkg::mats_rec_t pop_rec,
  output logic                full,
  output logic                empty
);
  import mats_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mats_rec_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pop_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/mats_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC address text splitter emitter
// Prints one record as sixteen characters, or one invalid transaction,
// through a registered output stage.
// ----------------------------------------------------------------------------
module mats_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                uppercase,
  input  logic                q_empty,
  input  mats_pkg::mats_rec_t q_rec,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [6:0]          out_char,
  output logic                half,
  output logic                valid_res,
  output logic                last_out
);
  import mats_pkg::*;

  logic                    busy;
  logic                    ok;
  logic [MATS_BYTES_W-1:0] bytes;
  logic [3:0]              idx;
  logic                    advance, finish;
  logic [5:0]              nib_lsb;
  logic [3:0]              nib;
  logic [6:0]              char_next;

  assign advance = busy && (!out_valid || out_ready);
  assign finish  = advance && (!ok || idx == MATS_LAST_IDX);
  assign q_pop   = (!busy || finish) && !q_empty;

  assign nib_lsb = 6'(MATS_BYTES_W - 4) - {mats_nib_index(idx), 2'b00};
  assign nib     = bytes[nib_lsb +: 4];

  always_comb begin
    if (idx[2:0] == 3'd2 || idx[2:0] == 3'd5) begin
      char_next = MATS_A_COLON;
    end else begin
      char_next = mats_hex_char(nib, uppercase);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !out_ready);
      if (q_pop) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ok    <= q_rec.ok;
      bytes <= q_rec.bytes;
      idx   <= '0;
    end else if (advance) begin
      idx <= idx + 4'd1;
    end
    if (advance) begin
      if (ok) begin
        out_char  <= char_next;
        half      <= idx[3];
        valid_res <= 1'b1;
        last_out  <= (idx == MATS_LAST_IDX);
      end else begin
        out_char  <= '0;
        half      <= 1'b0;
        valid_res <= 1'b0;
        last_out  <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/mac_address_text_splitter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC address text splitter
// Parses a MAC address given as 16-bit text code units and prints it back as
// vendor and device halves, "aa:bb:cc" each.
//
// Input channel: one code unit per transaction, last marks the end of an
// address. Accepts one unit per clock while the record queue has room.
// Output channel: 16 transactions for a well-formed address (vendor half,
// then device half, last_out on the final one), or one transaction with
// valid_res low for a malformed one. One character per clock while out_ready is high.
// Each record passes through the queue, the emitter's record register and the
// output register. The queue holds QUEUE_DEPTH parsed addresses, so input keeps
// flowing while the emitter prints; input stalls only when the queue is full.
// A stalled receiver holds the output register; the emitter and then the
// queue back up behind it.
// Reset clears the parser state, the queue and the output stage; uppercase
// returns to 0 (lower-case hex). cfg_wr_en writes uppercase directly.
// ----------------------------------------------------------------------------
module mac_address_text_splitter_unit #(
  parameter int QUEUE_DEPTH = mats_pkg::MATS_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_char,
  output logic        half,
  output logic        valid_res,
  output logic        last_out
);
  import mats_pkg::*;

  logic      uppercase;
  logic      q_push, q_pop, q_full, q_empty;
  mats_rec_t push_rec, pop_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      uppercase <= 1'b0;
    end else if (cfg_wr_en) begin
      uppercase <= cfg_wr_data;
    end
  end

  mats_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .code_unit (code_unit),
    .last      (last),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_rec     (push_rec)
  );

  mats_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .pop_rec  (pop_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  mats_back u_back (
    .clk       (clk),
    .rst       (rst),
    .uppercase (uppercase),
    .q_empty   (q_empty),
    .q_rec     (pop_rec),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .half      (half),
    .valid_res (valid_res),
    .last_out  (last_out)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("record queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("record queue underflow");

  a_invalid_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |-> (last_out && out_char == 7'd0))
    else $error("invalid result must be a single closing transaction");

  a_last_in_device: assert property (@(posedge clk) disable iff (rst)
    (out_valid && valid_res && last_out) |-> half)
    else $error("final valid character must belong to the device half");

endmodule

// ----- verif/mac_address_text_splitter_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC address text splitter testbench
// Feeds address text one code unit per transaction: a few fixed addresses
// (both separators of the 17-unit form, the dotted form, bad lengths, bad
// and wide separators, single-unit and overlong text), then random addresses.
// Most random addresses are well formed; the rest are mutated, resized,
// mixed or plain noise. Each closed address is parsed again here. The
// predicted characters are compared field by field with what the block
// prints. Both sides stall in random bursts, except in the last phase. The
// case setting changes between phases, and only once all output has drained.
// ----------------------------------------------------------------------------
module mac_address_text_splitter_unit_test;
  import mats_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_UNITS  = 16;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [6:0] ch;
    logic       part;
    logic       well_formed;
    logic       fin;
  } mac_char_t;

  class splitter_board;
    logic        upper;
    logic [4:0]  count;
    logic [15:0] first_sep;
    logic        colon_ok;
    logic        dot_ok;
    logic [47:0] colon_bytes;
    logic [47:0] dot_bytes;
    mac_char_t   due_chars[$];
    int          errors;

    function new();
      upper  = 1'b0;
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      count       = '0;
      first_sep   = '0;
      colon_ok    = 1'b1;
      dot_ok      = 1'b1;
      colon_bytes = '0;
      dot_bytes   = '0;
    endfunction

    function int nibble_of(logic [15:0] cu);
      if (cu >= 16'h0030 && cu <= 16'h0039) return int'(cu) - 'h30;
      if (cu >= 16'h0061 && cu <= 16'h0066) return int'(cu) - 'h61 + 10;
      if (cu >= 16'h0041 && cu <= 16'h0046) return int'(cu) - 'h41 + 10;
      return -1;
    endfunction

    function logic [6:0] digit_text(logic [3:0] n);
      if (n < 4'd10) return MATS_A_ZERO + 7'(n);
      return (upper ? MATS_A_UP_A : MATS_A_LOW_A) + 7'(n - 4'd10);
    endfunction

    function void push_char(logic [6:0] ch, logic part, logic fin);
      mac_char_t r;
      r.ch          = ch;
      r.part        = part;
      r.well_formed = 1'b1;
      r.fin         = fin;
      due_chars.push_back(r);
    endfunction

    // parse one accepted unit; a closing unit queues the printed address
    function void note_unit(logic [15:0] cu, logic closing);
      int          nib;
      logic        ok;
      logic [47:0] bytes;
      logic [7:0]  byte_val;
      mac_char_t   bad;
      nib = nibble_of(cu);
      if (count < MATS_COLON_LEN) begin
        if (count % 3 == 2) begin
          if (count == 5'd2) begin
            first_sep = cu;
            if (cu != MATS_U_COLON && cu != MATS_U_DASH) colon_ok = 1'b0;
          end else if (cu != first_sep) begin
            colon_ok = 1'b0;
          end
        end else if (nib < 0) begin
          colon_ok = 1'b0;
        end else begin
          colon_bytes = {colon_bytes[43:0], 4'(nib)};
        end
      end
      if (count < MATS_DOT_LEN) begin
        if (count == 5'd4 || count == 5'd9) begin
          if (cu != MATS_U_DOT) dot_ok = 1'b0;
        end else if (nib < 0) begin
          dot_ok = 1'b0;
        end else begin
          dot_bytes = {dot_bytes[43:0], 4'(nib)};
        end
      end
      if (count != MATS_COUNT_MAX) count = count + 5'd1;
      if (!closing) return;

      ok    = 1'b0;
      bytes = '0;
      if (count == MATS_COLON_LEN) begin
        ok    = colon_ok;
        bytes = colon_bytes;
      end else if (count == MATS_DOT_LEN) begin
        ok    = dot_ok;
        bytes = dot_bytes;
      end
      clear_text();
      if (!ok) begin
        bad = '{ch: 7'd0, part: 1'b0, well_formed: 1'b0, fin: 1'b1};
        due_chars.push_back(bad);
        return;
      end
      for (int i = 0; i < 6; i++) begin
        byte_val = bytes[47 - 8 * i -: 8];
        push_char(digit_text(byte_val[7:4]), i >= 3, 1'b0);
        push_char(digit_text(byte_val[3:0]), i >= 3, i == 5);
        if (i % 3 != 2) push_char(MATS_A_COLON, i >= 3, 1'b0);
      end
    endfunction

    function void check_char(logic [6:0] ch, logic part, logic well_formed, logic fin);
      mac_char_t exp_c;
      if (due_chars.size() == 0) begin
        $error("unexpected output char %0h", ch);
        errors++;
        return;
      end
      exp_c = due_chars.pop_front();
      if (ch != exp_c.ch) begin
        $error("out_char expected %0h actual %0h", exp_c.ch, ch);
        errors++;
      end
      if (part != exp_c.part) begin
        $error("half expected %0b actual %0b", exp_c.part, part);
        errors++;
      end
      if (well_formed != exp_c.well_formed) begin
        $error("valid_res expected %0b actual %0b", exp_c.well_formed, well_formed);
        errors++;
      end
      if (fin != exp_c.fin) begin
        $error("last_out expected %0b actual %0b", exp_c.fin, fin);
        errors++;
      end
    endfunction

    function int pending();
      return due_chars.size();
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [15:0] code_unit   = '0;
  logic        last        = 1'b0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [6:0]  out_char;
  logic        half;
  logic        valid_res;
  logic        last_out;

  splitter_board board = new();
  logic [15:0]   text[$];
  logic          idling_on = 1'b1;
  int            stall_left = 0;
  int            cycles = 0;

  mac_address_text_splitter_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .code_unit   (code_unit),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .half        (half),
    .valid_res   (valid_res),
    .last_out    (last_out)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: ready drops in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 11) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(1, 8) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_char(out_char, half, valid_res, last_out);
    end
  end

  function automatic logic [15:0] rand_hex();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 16'(MATS_A_ZERO) + 16'(v);
    if (v < 16) return 16'(MATS_A_LOW_A) + 16'(v - 10);
    return 16'(MATS_A_UP_A) + 16'(v - 16);
  endfunction

  function automatic logic [15:0] odd_unit();
    string near_hex;
    near_hex = "/:@G`gFf9";
    case ($urandom_range(0, 9))
      0: return rand_hex();
      1: return MATS_U_COLON;
      2: return MATS_U_DASH;
      3: return MATS_U_DOT;
      4: return 16'h0100 | 16'($urandom_range(0, 255));
      5: return 16'(near_hex[$urandom_range(0, near_hex.len() - 1)]);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic load_string(input string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(16'(s[i]));
  endtask

  task automatic build_colon(input logic [15:0] sep);
    text.delete();
    for (int i = 0; i < 17; i++) text.push_back(i % 3 == 2 ? sep : rand_hex());
  endtask

  task automatic build_dot();
    text.delete();
    for (int i = 0; i < 14; i++) text.push_back((i == 4 || i == 9) ? MATS_U_DOT : rand_hex());
  endtask

  task automatic build_good();
    case ($urandom_range(0, 2))
      0: build_colon(MATS_U_COLON);
      1: build_colon(MATS_U_DASH);
      default: build_dot();
    endcase
  endtask

  task automatic build_random_text();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      build_good();
    end else if (kind == 6) begin
      build_good();
      text[$urandom_range(0, text.size() - 1)] = odd_unit();
    end else if (kind == 7) begin
      build_good();
      if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 3)) void'(text.pop_back());
      end else begin
        repeat ($urandom_range(1, 20)) text.push_back(rand_hex());
      end
    end else if (kind == 8) begin
      text.delete();
      repeat ($urandom_range(1, 40)) text.push_back(odd_unit());
    end else if ($urandom_range(0, 1) == 0) begin
      build_colon(MATS_U_COLON);
      text[3 * $urandom_range(1, 4) + 2] = MATS_U_DASH;
    end else begin
      build_dot();
      text[$urandom_range(0, 1) == 0 ? 4 : 9] = MATS_U_COLON;
    end
  endtask

  task automatic send_unit(input logic [15:0] cu, input logic closing);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_unit <= cu;
    last      <= closing;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_unit(cu, closing);
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_unit(text[i], i == text.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_uppercase(input logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.upper = v;
  endtask

  initial begin
    int sent;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_uppercase(1'b0);
    load_string("0a:1B:2c:3D:4e:5F");
    send_text();
    load_string("FF-ff-00-99-aA-09");
    send_text();
    load_string("0123.4567.89aB");
    send_text();
    load_string("01:23-45:67:89:ab");   // mixed separators
    send_text();
    load_string("0123:4567:89ab");      // dotted length, wrong separator
    send_text();
    load_string("01:23:45:67:89:a");
    send_text();
    load_string("01:23:45:67:89:ab");
    text[2] = 16'h013A;                 // wide unit aliasing ':'
    send_text();
    load_string("00:11:22:33:44:550123456789abcdef");
    send_text();
    text.delete();
    text.push_back(16'hFFFF);
    send_text();
    text.delete();
    text.push_back(16'h0000);
    send_text();
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      idling_on = (phase < 3);
      write_uppercase(phase % 2 == 0);
      sent = 0;
      while (sent < PHASE_UNITS) begin
        build_random_text();
        send_text();
        sent += text.size();
      end
      wait_drained();
    end

    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mats_pkg.sv
rtl/mats_front.sv
rtl/mats_queue.sv
rtl/mats_back.sv
rtl/mac_address_text_splitter_unit.sv
verif/mac_address_text_splitter_unit_test.sv
